### rtl/core/fsms_pkg.sv
// shared types, constants and helpers for the fuzzy substring match scorer
`default_nettype none

package fsms_pkg;

  localparam logic [15:0] SCORE_ONE = 16'd32768;
  localparam int DIV_BITS = 15;
  localparam int GAP_SHIFT = 17;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_EXACT = 2'd1;
  localparam logic [1:0] KIND_SUBSEQ = 2'd2;

  localparam logic [1:0] CFG_QUERY_LOW = 2'd0;
  localparam logic [1:0] CFG_QUERY_HIGH = 2'd1;
  localparam logic [1:0] CFG_QUERY_LEN = 2'd2;

  typedef struct packed {
    logic step;
    logic prep;
    logic load;
    logic div_step;
    logic load_out;
  } fsms_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } fsms_status_t;

  function automatic logic [7:0] fold_char(input logic [7:0] ch);
    logic [7:0] r;
    r = ch;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      r = ch + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/fsms_ctrl.sv
// controller state machine: text streaming, scoring setup, divide and result handoff
`default_nettype none

module fsms_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  text_valid,
  input  wire logic                  text_end,
  output logic                       text_stall,
  input  fsms_pkg::fsms_status_t     status,
  output fsms_pkg::fsms_cmd_t        cmd
);
  import fsms_pkg::*;

  typedef enum logic [2:0] {
    S_RUN,
    S_PREP,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    cmd.step = text_valid && !text_stall;
    case (state)
      S_PREP: cmd.prep = 1'b1;
      S_LOAD: cmd.load = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_OUT: cmd.load_out = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      text_stall <= 1'b0;
    end else begin
      case (state)
        S_RUN: begin
          if (text_valid && !text_stall && text_end) begin
            state <= S_PREP;
            text_stall <= 1'b1;
          end
        end
        S_PREP: begin
          state <= status.need_div ? S_LOAD : S_OUT;
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (status.div_last) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (status.out_free) begin
            state <= S_RUN;
            text_stall <= 1'b0;
          end
        end
        default: begin
          state <= S_RUN;
          text_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/fsms_datapath.sv
// datapath: query registers, match tracking, penalty divider and result register
`default_nettype none

module fsms_datapath #(
  parameter int QUERY_MAX = 16,
  parameter int TEXT_MAX = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  input  wire logic [7:0]            text_char,
  input  wire logic                  char_valid,
  input  fsms_pkg::fsms_cmd_t        cmd,
  output fsms_pkg::fsms_status_t     status,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [15:0]                score,
  output logic [1:0]                 match_kind,
  output logic                       too_long
);
  import fsms_pkg::*;

  localparam int QW = (QUERY_MAX < 16) ? QUERY_MAX : 16;
  localparam int QLW = $clog2(QW + 1);
  localparam int CW = $clog2(TEXT_MAX + 1);
  localparam int PW = $clog2(TEXT_MAX);
  localparam int DW = PW + 6;
  localparam int NW = CW + GAP_SHIFT + 1;
  localparam int CNTW = $clog2(DIV_BITS);

  logic [63:0]          query_chars_low;
  logic [63:0]          query_chars_high;
  logic [4:0]           qry_len;

  logic [QW-1:0]        substring_vector;
  logic                 substring_found;
  logic [QLW-1:0]       subsequence_progress;
  logic [PW-1:0]        first_pos;
  logic [PW-1:0]        last_pos;
  logic                 any_matched;
  logic [CW-1:0]        characters_seen;
  logic                 overflowed;

  logic [CW-1:0]        gaps;
  logic [CW-1:0]        text_count;
  logic [1:0]           kind;
  logic                 long_flag;
  logic [NW-1:0]        rem;
  logic [NW-1:0]        divisor;
  logic [DIV_BITS-1:0]  quotient;
  logic [CNTW-1:0]      div_count;

  logic [7:0]           ch;
  logic [QLW-1:0]       qlen;
  logic [7:0]           qc [QW];
  logic [QW-1:0]        mask;
  logic [QW-1:0]        vector_next;
  logic                 found_hit;
  logic                 prog_hit;
  logic                 in_range;
  logic [PW-1:0]        pos;
  logic [1:0]           kind_now;
  logic [DW-1:0]        span_diff;
  logic [CW-1:0]        gaps_now;
  logic [NW-1:0]        num_init;
  logic [NW-1:0]        den_init;

  assign ch = fold_char(text_char);
  assign qlen = (qry_len > 5'(QW)) ? QLW'(QW) : qry_len[QLW-1:0];
  assign in_range = characters_seen < CW'(TEXT_MAX);
  assign pos = characters_seen[PW-1:0];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      if (i < 8) begin
        qc[i] = fold_char(query_chars_low[8*(i%8) +: 8]);
      end else begin
        qc[i] = fold_char(query_chars_high[8*(i%8) +: 8]);
      end
    end
  end

  always_comb begin
    found_hit = 1'b0;
    prog_hit = 1'b0;
    for (int i = 0; i < QW; i++) begin
      mask[i] = (qc[i] == ch) && (QLW'(i) < qlen);
    end
    vector_next = QW'({substring_vector, 1'b1}) & mask;
    for (int i = 0; i < QW; i++) begin
      if (vector_next[i] && (QLW'(i + 1) == qlen)) begin
        found_hit = 1'b1;
      end
      if ((subsequence_progress == QLW'(i)) && (qc[i] == ch)) begin
        prog_hit = 1'b1;
      end
    end
    prog_hit = prog_hit && (subsequence_progress < qlen);
  end

  // scoring decision, taken once the last character is in
  always_comb begin
    if (qlen == '0 || (characters_seen != '0 && substring_found)) begin
      kind_now = KIND_EXACT;
    end else if (characters_seen != '0 && subsequence_progress >= qlen) begin
      kind_now = KIND_SUBSEQ;
    end else begin
      kind_now = KIND_NONE;
    end
    span_diff = DW'(last_pos) - DW'(first_pos) + DW'(1) - DW'(qlen);
    gaps_now = span_diff[DW-1] ? '0 : span_diff[CW-1:0];
  end

  // numerator 2*65536*gaps + 5*n, divisor 10*n aligned to the top quotient bit
  assign num_init = (NW'(gaps) << GAP_SHIFT) + (NW'(text_count) << 2) + NW'(text_count);
  assign den_init = ((NW'(text_count) << 3) + (NW'(text_count) << 1)) << (DIV_BITS - 1);

  assign status.need_div = (kind_now == KIND_SUBSEQ);
  assign status.div_last = (div_count == '0);
  assign status.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_chars_low <= '0;
      query_chars_high <= '0;
      qry_len <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUERY_LOW: query_chars_low <= cfg_data;
        CFG_QUERY_HIGH: query_chars_high <= cfg_data;
        CFG_QUERY_LEN: qry_len <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // per-text match state
  always_ff @(posedge clk) begin
    if (rst || cmd.prep) begin
      substring_vector <= '0;
      substring_found <= 1'b0;
      subsequence_progress <= '0;
      first_pos <= '0;
      last_pos <= '0;
      any_matched <= 1'b0;
      characters_seen <= '0;
      overflowed <= 1'b0;
    end else if (cmd.step && char_valid) begin
      if (!in_range) begin
        overflowed <= 1'b1;
      end else begin
        substring_vector <= vector_next;
        if (found_hit) begin
          substring_found <= 1'b1;
        end
        if (prog_hit) begin
          if (!any_matched) begin
            first_pos <= pos;
          end
          last_pos <= pos;
          any_matched <= 1'b1;
          subsequence_progress <= subsequence_progress + QLW'(1);
        end
        characters_seen <= characters_seen + CW'(1);
      end
    end
  end

  // scoring setup and restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      kind <= kind_now;
      long_flag <= overflowed;
      gaps <= gaps_now;
      text_count <= characters_seen;
    end
    if (cmd.load) begin
      rem <= num_init;
      divisor <= den_init;
      quotient <= '0;
      div_count <= CNTW'(DIV_BITS - 1);
    end else if (cmd.div_step) begin
      if (rem >= divisor) begin
        rem <= rem - divisor;
        quotient <= {quotient[DIV_BITS-2:0], 1'b1};
      end else begin
        quotient <= {quotient[DIV_BITS-2:0], 1'b0};
      end
      divisor <= divisor >> 1;
      div_count <= div_count - CNTW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (kind)
        KIND_SUBSEQ: score <= SCORE_ONE - {1'b0, quotient};
        KIND_EXACT: score <= SCORE_ONE;
        default: score <= '0;
      endcase
      match_kind <= kind;
      too_long <= long_flag;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fuzzy_substring_match_scorer_core.sv
// top level of the fuzzy substring match scorer
//
// A text streams in on the text channel (text_valid / text_stall), one byte
// per transaction; char_valid = 0 carries no character (empty text) and
// text_end marks the last transaction of a text. Only the end transaction
// produces a result on the result channel (result_valid / result_stall):
// score in Q1.15, match_kind and too_long.
// The query is written on the cfg channel (cfg_index 0/1: query bytes,
// 2: query length); cfg_ready is always high. Write it only while idle.
// Throughput: one character per cycle while text_stall is low. After the end
// transaction text_stall rises and holds through the setup and output states
// (exact, empty query or no match) or through setup, load, the bit-serial penalty
// divider and output (subsequence hit); the result shows up when text_stall falls.
// A held result does not block the next text; a new end transaction waits
// in the output stage until the previous result is taken.
// Reset clears the query registers, the per-text match state and result_valid.
`default_nettype none

module fuzzy_substring_match_scorer_core #(
  parameter int QUERY_MAX = 16,
  parameter int TEXT_MAX = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        text_valid,
  output logic             text_stall,
  input  wire logic [7:0]  text_char,
  input  wire logic        char_valid,
  input  wire logic        text_end,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [15:0]      score,
  output logic [1:0]       match_kind,
  output logic             too_long
);
  import fsms_pkg::*;

  fsms_cmd_t    cmd;
  fsms_status_t status;

  assign cfg_ready = 1'b1;

  fsms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_end   (text_end),
    .text_stall (text_stall),
    .status     (status),
    .cmd        (cmd)
  );

  fsms_datapath #(
    .QUERY_MAX (QUERY_MAX),
    .TEXT_MAX  (TEXT_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .text_char    (text_char),
    .char_valid   (char_valid),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .score        (score),
    .match_kind   (match_kind),
    .too_long     (too_long)
  );

  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_stall && text_end) |=> text_stall)
    else $error("text channel open right after end transaction");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (match_kind == KIND_NONE || match_kind == KIND_EXACT ||
                      match_kind == KIND_SUBSEQ))
    else $error("undefined match kind on result");

  a_exact_score: assert property (@(posedge clk) disable iff (rst)
    (result_valid && match_kind == KIND_EXACT) |-> (score == SCORE_ONE))
    else $error("exact match without full score");

  a_none_score: assert property (@(posedge clk) disable iff (rst)
    (result_valid && match_kind == KIND_NONE) |-> (score == 16'd0))
    else $error("no match with nonzero score");

  a_subseq_score: assert property (@(posedge clk) disable iff (rst)
    (result_valid && match_kind == KIND_SUBSEQ) |-> (score != 16'd0 && score <= SCORE_ONE))
    else $error("subsequence score out of range");

endmodule

`default_nettype wire
